// ===== rtl/tmsm_pkg.sv =====
// Package for the trimmed-mean supply monitor: widths, constants, payload
// and inter-module structs. No dependencies.
`default_nettype none

package tmsm_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W      = 12;
  localparam int SUM_W         = 16;
  localparam int REF_W         = 24;
  localparam int MV_W          = 16;
  localparam int MEAN_SHIFT    = 3;

  // Batch size and counter width
  localparam int BATCH_SAMPLES = 10;
  localparam int CNT_W         = $clog2(BATCH_SAMPLES + 1);

  // Serial divider: one quotient bit per cycle over the whole numerator
  localparam int DIV_STEPS     = REF_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [REF_W-1:0] REF_SCALE_RESET = REF_W'(4915200);
  localparam logic [MV_W-1:0]  MV_MAX          = {MV_W{1'b1}};

  // Input item
  typedef struct packed {
    logic [7:0] sample_high;
    logic [7:0] sample_low;
    logic       abort;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [MV_W-1:0]     supply_mv;
    logic                saturated;
  } out_item_t;

  // Accumulator status toward the top level
  typedef struct packed {
    logic                done;
    logic                near_full;
    logic [SAMPLE_W-1:0] mean;
  } acc_stat_t;

  // Divider request and response
  typedef struct packed {
    logic                start;
    logic [REF_W-1:0]    dividend;
    logic [SAMPLE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [REF_W-1:0]    quotient;
    logic [SAMPLE_W-1:0] divisor;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tmsm_accum.sv =====
// Batch accumulator: running sum, largest and smallest of one batch, and
// the trimmed mean at batch end. Depends on tmsm_pkg.
`default_nettype none

module tmsm_accum
  import tmsm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take_sample,
  input  wire logic                take_abort,
  input  wire logic [SAMPLE_W-1:0] sample,
  output acc_stat_t                stat
);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic                done_r, done_nxt;
  logic                last_sample;
  logic [SUM_W-1:0]    trim1, trim2;

  assign last_sample = (count_r == CNT_W'(BATCH_SAMPLES - 1));

  // Batch update; the first sample sets both extremes
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    done_nxt  = 1'b0;
    if (take_abort || done_r) begin
      count_nxt = '0;
      sum_nxt   = '0;
      max_nxt   = '0;
      min_nxt   = '0;
    end else if (take_sample) begin
      sum_nxt = sum_r + SUM_W'(sample);
      if (count_r == '0) begin
        max_nxt = sample;
        min_nxt = sample;
      end else if (sample > max_r) begin
        max_nxt = sample;
      end else if (sample < min_r) begin
        min_nxt = sample;
      end
      if (last_sample) begin
        count_nxt = '0;
        done_nxt  = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      max_r   <= '0;
      min_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      done_r  <= done_nxt;
    end
  end

  // Drop the extremes (clamped at zero), then divide by eight
  assign trim1 = (sum_r >= SUM_W'(max_r)) ? sum_r - SUM_W'(max_r) : '0;
  assign trim2 = (trim1 >= SUM_W'(min_r)) ? trim1 - SUM_W'(min_r) : '0;

  assign stat.done      = done_r;
  assign stat.near_full = last_sample;
  assign stat.mean      = trim2[MEAN_SHIFT +: SAMPLE_W];

  // A batch end always comes from a sample, never from an abort
  a_done_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(take_sample) && !$past(take_abort))
    else $error("batch end without a sample transfer");

endmodule

`default_nettype wire

// ===== rtl/tmsm_div.sv =====
// Restoring serial divider, one quotient bit per cycle; the numerator
// shifts out of the top of a register while quotient bits shift in.
// Depends on tmsm_pkg.
`default_nettype none

module tmsm_div
  import tmsm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [REF_W-1:0]     quo_r, quo_nxt;
  logic [SAMPLE_W-1:0]  rem_r, rem_nxt;
  logic [SAMPLE_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [SAMPLE_W:0]    trial, diff;
  logic                 fits;

  // One restoring step; a zero divisor yields all ones, which saturates
  assign trial = {rem_r, quo_r[REF_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[REF_W-2:0], fits};
      rem_nxt = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
  assign rsp.divisor  = dvs_r;

  // Step counter runs only while busy
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0)
    else $error("divider step count nonzero while idle");

  // Done follows the last step
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a preceding step");

endmodule

`default_nettype wire

// ===== rtl/trimmed_mean_supply_monitor.sv =====
// Top level of the trimmed-mean supply monitor: channels, reference-scale
// register, output register. Depends on tmsm_pkg, tmsm_accum, tmsm_div.
//
// Usage:
//  - in_*: one ADC conversion per transfer (sample_high, sample_low, abort).
//    Sample = sample_high*16 + sample_low[7:4]. An abort transfer discards
//    the current batch and gives no result.
//  - Every tenth sample closes a batch: the extremes are dropped, the mean of
//    the remaining eight is formed, and ref_scale / mean goes through a
//    serial divider, one quotient bit per cycle for 24 steps.
//  - out_*: one result per batch (mean, supply_mv, saturated). supply_mv is
//    65535 with saturated set when the quotient exceeds 16 bits or mean is 0.
//  - Result path: the tenth sample transfer closes the batch, the divider
//    runs its 24 steps, and then the output register is loaded.
//  - Input: a closing sample holds in_ready low while the batch closes and
//    through the 24 divider steps.
//  - A stalled receiver holds the result in the output register; samples of
//    the next batch are still taken, up to its ninth.
//  - cfg_*: writes ref_scale (24 bits), always ready; reset value 4915200.
//  - Reset (rst_n low, synchronous) clears the batch, the divider and the
//    output register and restores ref_scale.
`default_nettype none

module trimmed_mean_supply_monitor
  import tmsm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [REF_W-1:0] cfg_data
);

  logic [REF_W-1:0] ref_scale_r, ref_scale_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             in_xfer;
  acc_stat_t        acc;
  div_req_t         dreq;
  div_rsp_t         drsp;
  logic             quo_over;

  // Configuration register
  assign cfg_ready     = 1'b1;
  assign ref_scale_nxt = (cfg_valid && cfg_ready) ? cfg_data : ref_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_scale_r <= REF_SCALE_RESET;
    end else begin
      ref_scale_r <= ref_scale_nxt;
    end
  end

  // Input side: hold off while a batch is closing or dividing, and before
  // a closing sample while the previous result is still unread
  assign in_ready = !drsp.busy && !acc.done && !(acc.near_full && out_valid_r);
  assign in_xfer  = in_valid && in_ready;

  tmsm_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .take_sample (in_xfer && !in_data.abort),
    .take_abort  (in_xfer && in_data.abort),
    .sample      ({in_data.sample_high, in_data.sample_low[7:4]}),
    .stat        (acc)
  );

  assign dreq.start    = acc.done;
  assign dreq.dividend = ref_scale_r;
  assign dreq.divisor  = acc.mean;

  tmsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Output register with saturation
  assign quo_over = |drsp.quotient[REF_W-1:MV_W];

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (drsp.done) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.mean      = drsp.divisor;
      out_data_nxt.supply_mv = quo_over ? MV_MAX : drsp.quotient[MV_W-1:0];
      out_data_nxt.saturated = quo_over;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // No sample transfer while the divider works
  a_no_in_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.busy |-> !in_ready)
    else $error("input transfer allowed while dividing");

  // A new result never lands on an unread one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> !out_valid_r)
    else $error("result overwrites an unread result");

  // Zero mean always reports saturation
  a_zero_mean_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.mean == '0 |-> out_data_r.saturated)
    else $error("zero mean without saturation");

  // A batch close starts the divider on the next cycle
  a_close_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    acc.done |=> drsp.busy)
    else $error("divider not started after batch close");

endmodule

`default_nettype wire
